### hw/rtl/prsp_pkg.sv
// ----------------------------------------------------------------------------
// PWM ramp sequence player package
// Shared constants, codes, types and index helpers of the sequence player.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package prsp_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);

  localparam int DIV_STEPS   = 16;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

  typedef logic [IDX_W-1:0] idx_t;

  // Item function codes.
  localparam logic [1:0] FUNC_TICK = 2'd0;
  localparam logic [1:0] FUNC_ON   = 2'd1;
  localparam logic [1:0] FUNC_OFF  = 2'd2;
  localparam logic [1:0] FUNC_LOAD = 2'd3;

  // Table entry command codes.
  localparam logic [2:0] CMD_INITIAL = 3'd0;
  localparam logic [2:0] CMD_SLOPE   = 3'd1;
  localparam logic [2:0] CMD_INSTANT = 3'd2;
  localparam logic [2:0] CMD_END     = 3'd3;
  localparam logic [2:0] CMD_LOOP    = 3'd4;

  typedef enum logic [2:0] {
    PS_IDLE,
    PS_START,
    PS_STOP,
    PS_FIRST,
    PS_HOLD,
    PS_RAMP,
    PS_ADVANCE
  } play_state_e;

  typedef enum logic [1:0] {
    DIR_HOLD,
    DIR_UP,
    DIR_DOWN
  } dir_e;

  typedef enum logic [3:0] {
    SQ_IDLE,
    SQ_EXEC,
    SQ_RAMP,
    SQ_FIRST_A,
    SQ_FIRST_B,
    SQ_ADV_A,
    SQ_ADV_B,
    SQ_PLAN,
    SQ_DIV,
    SQ_EMIT
  } seq_state_e;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] dur;
    logic [7:0] level;
  } entry_t;

  typedef struct packed {
    logic [1:0] func;
    logic [3:0] entry_index;
    logic [2:0] entry_cmd;
    logic [7:0] entry_time;
    logic [7:0] entry_level;
  } in_item_t;

  typedef struct packed {
    logic   en;
    idx_t   addr;
    entry_t data;
  } tab_wr_t;

  typedef struct packed {
    logic en;
    idx_t addr;
  } tab_rd_t;

  typedef struct packed {
    logic        start;
    logic [15:0] dividend;
    logic [7:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [15:0] quot;
    logic        rem_nz;
  } div_rsp_t;

  typedef struct packed {
    logic       valid;
    logic       wr;
    logic [7:0] duty;
    logic       busy;
  } res_t;

  function automatic idx_t idx_inc(input idx_t i);
    idx_t r;
    if (i == idx_t'(TABLE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = i + idx_t'(1);
    end
    return r;
  endfunction

  function automatic idx_t idx_dec(input idx_t i);
    idx_t r;
    if (i == '0) begin
      r = idx_t'(TABLE_DEPTH - 1);
    end else begin
      r = i - idx_t'(1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/prsp_if.sv
// ----------------------------------------------------------------------------
// PWM ramp sequence player channels
// Valid/ready interfaces for the item input and the result output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface prsp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [3:0] entry_index;
  logic [2:0] entry_cmd;
  logic [7:0] entry_time;
  logic [7:0] entry_level;

  modport source (
    output valid, func, entry_index, entry_cmd, entry_time, entry_level,
    input  ready
  );
  modport sink (
    input  valid, func, entry_index, entry_cmd, entry_time, entry_level,
    output ready
  );
endinterface

interface prsp_out_if;
  logic       valid;
  logic       ready;
  logic       duty_write;
  logic [7:0] duty_level;
  logic       busy_res;

  modport source (
    output valid, duty_write, duty_level, busy_res,
    input  ready
  );
  modport sink (
    input  valid, duty_write, duty_level, busy_res,
    output ready
  );
endinterface

`default_nettype wire

### hw/rtl/prsp_table.sv
// ----------------------------------------------------------------------------
// Pattern table
// One write port and one registered read port over the pattern entries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module prsp_table (
  input  wire logic              clk_i,
  input  wire prsp_pkg::tab_wr_t tab_wr_i,
  input  wire prsp_pkg::tab_rd_t tab_rd_i,
  output prsp_pkg::entry_t       rd_data_o
);

  prsp_pkg::entry_t mem_q [prsp_pkg::TABLE_DEPTH];
  prsp_pkg::entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (tab_wr_i.en) begin
      mem_q[tab_wr_i.addr] <= tab_wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tab_rd_i.en) begin
      rd_q <= mem_q[tab_rd_i.addr];
    end
  end

  assign rd_data_o = rd_q;

endmodule

`default_nettype wire

### hw/rtl/prsp_div.sv
// ----------------------------------------------------------------------------
// Serial divider
// Restoring 16 by 8 bit divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module prsp_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire prsp_pkg::div_req_t req_i,
  output prsp_pkg::div_rsp_t      rsp_o
);

  logic [prsp_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [15:0]                    quo_q, quo_d;
  logic [7:0]                     rem_q, rem_d;
  logic [7:0]                     dvs_q, dvs_d;
  logic [8:0]                     shifted;
  logic [8:0]                     diff;
  logic                           fits;

  assign shifted = {rem_q, quo_q[15]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign fits    = shifted >= {1'b0, dvs_q};

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      cnt_d  = prsp_pkg::DIV_CNT_W'(prsp_pkg::DIV_STEPS);
      busy_d = 1'b1;
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      // The remainder stays below the divisor, so eight bits hold it.
      rem_d = fits ? diff[7:0] : shifted[7:0];
      quo_d = {quo_q[14:0], fits};
      cnt_d = cnt_q - prsp_pkg::DIV_CNT_W'(1);
      if (cnt_q == prsp_pkg::DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy   = busy_q;
  assign rsp_o.done   = done_q;
  assign rsp_o.quot   = quo_q;
  assign rsp_o.rem_nz = rem_q != '0;

endmodule

`default_nettype wire

### hw/rtl/prsp_seq.sv
// ----------------------------------------------------------------------------
// Sequence player control
// Per-item sequencer holding the playback state, ramp datapath and planning.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module prsp_seq (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire prsp_pkg::in_item_t item_i,
  input  wire logic               emit_ok_i,
  output prsp_pkg::res_t          res_o,
  output prsp_pkg::tab_wr_t       tab_wr_o,
  output prsp_pkg::tab_rd_t       tab_rd_o,
  input  wire prsp_pkg::entry_t   rd_data_i,
  output prsp_pkg::div_req_t      div_req_o,
  input  wire prsp_pkg::div_rsp_t div_rsp_i
);

  prsp_pkg::seq_state_e  seq_q, seq_d;
  prsp_pkg::play_state_e play_q, play_d;
  prsp_pkg::dir_e        dir_q, dir_d;
  prsp_pkg::idx_t        ptr_q, ptr_d;
  logic [15:0]           ramp_q, ramp_d;
  logic [7:0]            tgt_q, tgt_d;
  logic signed [16:0]    step_q, step_d;
  logic [7:0]            hold_q, hold_d;

  prsp_pkg::in_item_t    item_q, item_d;
  prsp_pkg::entry_t      ent_q, ent_d;
  logic [7:0]            from_q, from_d;
  logic                  first_q, first_d;
  logic                  neg_q, neg_d;
  logic                  res_wr_q, res_wr_d;
  logic [7:0]            res_duty_q, res_duty_d;

  logic                  accept;
  logic                  plan_direct;
  logic signed [8:0]     plan_diff;
  logic                  plan_neg;
  logic [7:0]            plan_mag;
  prsp_pkg::dir_e        plan_dir;
  logic signed [17:0]    ramp_sum;
  logic [15:0]           ramp_clip;
  logic [15:0]           tgt_fix;
  logic                  ramp_hit;
  logic [7:0]            hold_next;
  logic [15:0]           quot_up;

  assign accept = in_valid_i && in_ready_o;

  // Segment planning from the start level toward the latched target entry.
  assign plan_diff   = $signed({1'b0, ent_q.level}) - $signed({1'b0, from_q});
  assign plan_neg    = ent_q.level < from_q;
  assign plan_mag    = plan_neg ? (from_q - ent_q.level) : (ent_q.level - from_q);
  assign plan_dir    = (ent_q.level == from_q) ? prsp_pkg::DIR_HOLD :
                       (plan_neg ? prsp_pkg::DIR_DOWN : prsp_pkg::DIR_UP);
  assign plan_direct = (ent_q.dur == 8'd0) || (ent_q.cmd == prsp_pkg::CMD_INSTANT);

  // One ramp tick, saturated to the unsigned 8.8 range.
  assign ramp_sum = $signed({2'b00, ramp_q}) + $signed({step_q[16], step_q});
  always_comb begin
    if (ramp_sum < 0) begin
      ramp_clip = 16'h0000;
    end else if (ramp_sum[17:16] != 2'b00) begin
      ramp_clip = 16'hffff;
    end else begin
      ramp_clip = ramp_sum[15:0];
    end
  end
  assign tgt_fix  = {tgt_q, 8'h00};
  assign ramp_hit = ((dir_q == prsp_pkg::DIR_DOWN) && (ramp_clip <= tgt_fix)) ||
                    ((dir_q == prsp_pkg::DIR_UP) && (ramp_clip >= tgt_fix));

  // A hold of zero ticks ends on the same tick as a hold of one.
  assign hold_next = (hold_q != 8'd0) ? (hold_q - 8'd1) : 8'd0;

  // Rounded-up quotient; it cannot overflow since the dividend is at most
  // 255 * 256.
  assign quot_up = div_rsp_i.quot + {15'd0, div_rsp_i.rem_nz};

  // Sequencer next state.
  always_comb begin
    seq_d = seq_q;
    unique case (seq_q)
      prsp_pkg::SQ_IDLE: begin
        if (accept) begin
          seq_d = prsp_pkg::SQ_EXEC;
        end
      end
      prsp_pkg::SQ_EXEC: begin
        seq_d = prsp_pkg::SQ_EMIT;
        if (item_q.func == prsp_pkg::FUNC_TICK) begin
          unique case (play_q)
            prsp_pkg::PS_FIRST:   seq_d = prsp_pkg::SQ_FIRST_A;
            prsp_pkg::PS_RAMP:    seq_d = prsp_pkg::SQ_RAMP;
            prsp_pkg::PS_ADVANCE: seq_d = prsp_pkg::SQ_ADV_A;
            default:              seq_d = prsp_pkg::SQ_EMIT;
          endcase
        end
      end
      prsp_pkg::SQ_RAMP:    seq_d = prsp_pkg::SQ_EMIT;
      prsp_pkg::SQ_FIRST_A: seq_d = prsp_pkg::SQ_FIRST_B;
      prsp_pkg::SQ_FIRST_B: seq_d = prsp_pkg::SQ_PLAN;
      prsp_pkg::SQ_ADV_A: begin
        if ((rd_data_i.cmd == prsp_pkg::CMD_END) ||
            (rd_data_i.cmd == prsp_pkg::CMD_LOOP)) begin
          seq_d = prsp_pkg::SQ_EMIT;
        end else begin
          seq_d = prsp_pkg::SQ_ADV_B;
        end
      end
      prsp_pkg::SQ_ADV_B: seq_d = prsp_pkg::SQ_PLAN;
      prsp_pkg::SQ_PLAN:  seq_d = plan_direct ? prsp_pkg::SQ_EMIT : prsp_pkg::SQ_DIV;
      prsp_pkg::SQ_DIV: begin
        if (div_rsp_i.done) begin
          seq_d = prsp_pkg::SQ_EMIT;
        end
      end
      prsp_pkg::SQ_EMIT: begin
        if (emit_ok_i) begin
          seq_d = prsp_pkg::SQ_IDLE;
        end
      end
      default: seq_d = prsp_pkg::SQ_IDLE;
    endcase
  end

  // Datapath and control outputs.
  always_comb begin
    play_d     = play_q;
    dir_d      = dir_q;
    ptr_d      = ptr_q;
    ramp_d     = ramp_q;
    tgt_d      = tgt_q;
    step_d     = step_q;
    hold_d     = hold_q;
    item_d     = item_q;
    ent_d      = ent_q;
    from_d     = from_q;
    first_d    = first_q;
    neg_d      = neg_q;
    res_wr_d   = res_wr_q;
    res_duty_d = res_duty_q;

    tab_wr_o.en   = 1'b0;
    tab_wr_o.addr = item_q.entry_index[prsp_pkg::IDX_W-1:0];
    tab_wr_o.data = '{cmd: item_q.entry_cmd, dur: item_q.entry_time,
                      level: item_q.entry_level};
    tab_rd_o.en   = 1'b0;
    tab_rd_o.addr = ptr_q;

    div_req_o.start    = 1'b0;
    div_req_o.dividend = {plan_mag, 8'h00};
    div_req_o.divisor  = ent_q.dur;

    unique case (seq_q)
      prsp_pkg::SQ_IDLE: begin
        if (accept) begin
          item_d = item_i;
        end
      end
      prsp_pkg::SQ_EXEC: begin
        res_wr_d   = 1'b0;
        res_duty_d = 8'd0;
        unique case (item_q.func)
          prsp_pkg::FUNC_ON:   play_d = prsp_pkg::PS_START;
          prsp_pkg::FUNC_OFF:  play_d = prsp_pkg::PS_STOP;
          prsp_pkg::FUNC_LOAD: tab_wr_o.en = 1'b1;
          default: begin
            unique case (play_q)
              prsp_pkg::PS_START, prsp_pkg::PS_STOP: begin
                ptr_d    = '0;
                ramp_d   = '0;
                res_wr_d = 1'b1;
                play_d   = (play_q == prsp_pkg::PS_START) ? prsp_pkg::PS_FIRST :
                                                            prsp_pkg::PS_IDLE;
              end
              prsp_pkg::PS_HOLD: begin
                hold_d = hold_next;
                if (hold_next == 8'd0) begin
                  play_d = prsp_pkg::PS_ADVANCE;
                end
              end
              prsp_pkg::PS_FIRST, prsp_pkg::PS_RAMP: begin
                tab_rd_o.en = 1'b1;
              end
              prsp_pkg::PS_ADVANCE: begin
                tab_rd_o.en   = 1'b1;
                tab_rd_o.addr = prsp_pkg::idx_inc(ptr_q);
              end
              default: ;
            endcase
          end
        endcase
      end
      prsp_pkg::SQ_RAMP: begin
        ramp_d     = ramp_clip;
        res_wr_d   = 1'b1;
        res_duty_d = ramp_hit ? tgt_q : ramp_clip[15:8];
        if (ramp_hit) begin
          play_d = prsp_pkg::PS_ADVANCE;
        end
        // The current entry, not the target, decides the instant hold.
        if (rd_data_i.cmd == prsp_pkg::CMD_INSTANT) begin
          play_d = prsp_pkg::PS_HOLD;
        end
      end
      prsp_pkg::SQ_FIRST_A: begin
        ramp_d        = {rd_data_i.level, 8'h00};
        res_wr_d      = 1'b1;
        res_duty_d    = rd_data_i.level;
        from_d        = rd_data_i.level;
        first_d       = 1'b1;
        tab_rd_o.en   = 1'b1;
        tab_rd_o.addr = prsp_pkg::idx_inc(ptr_q);
      end
      prsp_pkg::SQ_FIRST_B: begin
        ent_d = rd_data_i;
      end
      prsp_pkg::SQ_ADV_A: begin
        ptr_d = prsp_pkg::idx_inc(ptr_q);
        if (rd_data_i.cmd == prsp_pkg::CMD_END) begin
          play_d = prsp_pkg::PS_IDLE;
        end else if (rd_data_i.cmd == prsp_pkg::CMD_LOOP) begin
          ptr_d  = '0;
          play_d = prsp_pkg::PS_FIRST;
        end else begin
          ent_d         = rd_data_i;
          first_d       = 1'b0;
          tab_rd_o.en   = 1'b1;
          tab_rd_o.addr = prsp_pkg::idx_dec(prsp_pkg::idx_inc(ptr_q));
        end
      end
      prsp_pkg::SQ_ADV_B: begin
        from_d = rd_data_i.level;
      end
      prsp_pkg::SQ_PLAN: begin
        tgt_d  = ent_q.level;
        hold_d = ent_q.dur;
        dir_d  = plan_dir;
        neg_d  = plan_neg;
        if ((plan_dir == prsp_pkg::DIR_HOLD) ||
            (first_q && (ent_q.cmd == prsp_pkg::CMD_INSTANT))) begin
          play_d = prsp_pkg::PS_HOLD;
        end else begin
          play_d = prsp_pkg::PS_RAMP;
        end
        if (plan_direct) begin
          step_d = {plan_diff, 8'h00};
        end else begin
          div_req_o.start = 1'b1;
        end
      end
      prsp_pkg::SQ_DIV: begin
        if (div_rsp_i.done) begin
          step_d = neg_q ? -$signed({1'b0, quot_up}) : $signed({1'b0, quot_up});
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q  <= prsp_pkg::SQ_IDLE;
      play_q <= prsp_pkg::PS_IDLE;
      dir_q  <= prsp_pkg::DIR_HOLD;
      ptr_q  <= '0;
      ramp_q <= '0;
      tgt_q  <= '0;
      step_q <= '0;
      hold_q <= '0;
    end else begin
      seq_q  <= seq_d;
      play_q <= play_d;
      dir_q  <= dir_d;
      ptr_q  <= ptr_d;
      ramp_q <= ramp_d;
      tgt_q  <= tgt_d;
      step_q <= step_d;
      hold_q <= hold_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    ent_q      <= ent_d;
    from_q     <= from_d;
    first_q    <= first_d;
    neg_q      <= neg_d;
    res_wr_q   <= res_wr_d;
    res_duty_q <= res_duty_d;
  end

  assign in_ready_o  = seq_q == prsp_pkg::SQ_IDLE;
  assign res_o.valid = seq_q == prsp_pkg::SQ_EMIT;
  assign res_o.wr    = res_wr_q;
  assign res_o.duty  = res_duty_q;
  assign res_o.busy  = play_q != prsp_pkg::PS_IDLE;

endmodule

`default_nettype wire

### hw/rtl/pwm_ramp_sequence_player.sv
// ----------------------------------------------------------------------------
// PWM ramp sequence player
// Loads a pattern table and plays it back on ticks as PWM duty levels.
//
// Every input transaction (tick, switch on, switch off or table load) gives
// exactly one output transaction carrying the duty write flag, the duty level
// and the busy flag. The block handles one transaction at a time: a load, a
// switch command or a tick that only holds goes through the execute and emit
// states; a tick that reads the table also goes through the read states;
// a tick that plans a new sloped segment also waits for the serial divider,
// which works out the ramp step one quotient bit per cycle.
// Table reads go through a single registered read port, one entry per cycle.
// A finished result waits in the output register, and the next transaction
// is accepted meanwhile; it stalls only at its own result. Table entries that
// were never loaded read as whatever the memory holds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pwm_ramp_sequence_player (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  prsp_in_if.sink     in_i,
  prsp_out_if.source  out_o
);

  prsp_pkg::in_item_t item;
  prsp_pkg::res_t     res;
  prsp_pkg::tab_wr_t  tab_wr;
  prsp_pkg::tab_rd_t  tab_rd;
  prsp_pkg::entry_t   rd_data;
  prsp_pkg::div_req_t div_req;
  prsp_pkg::div_rsp_t div_rsp;
  logic               seq_ready;
  logic               emit_ok;

  logic               out_valid_q, out_valid_d;
  logic               out_wr_q, out_wr_d;
  logic [7:0]         out_duty_q, out_duty_d;
  logic               out_busy_q, out_busy_d;

  assign item = '{func: in_i.func, entry_index: in_i.entry_index,
                  entry_cmd: in_i.entry_cmd, entry_time: in_i.entry_time,
                  entry_level: in_i.entry_level};

  // The sequencer may hand over its result when the output register is empty
  // or is being emptied in this same cycle.
  assign emit_ok = !out_valid_q || out_o.ready;

  prsp_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (seq_ready),
    .item_i     (item),
    .emit_ok_i  (emit_ok),
    .res_o      (res),
    .tab_wr_o   (tab_wr),
    .tab_rd_o   (tab_rd),
    .rd_data_i  (rd_data),
    .div_req_o  (div_req),
    .div_rsp_i  (div_rsp)
  );

  prsp_table u_table (
    .clk_i     (clk_i),
    .tab_wr_i  (tab_wr),
    .tab_rd_i  (tab_rd),
    .rd_data_o (rd_data)
  );

  prsp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Output register: it holds one finished result until the sink takes it.
  always_comb begin
    out_valid_d = out_valid_q;
    out_wr_d    = out_wr_q;
    out_duty_d  = out_duty_q;
    out_busy_d  = out_busy_q;
    if (res.valid && emit_ok) begin
      out_valid_d = 1'b1;
      out_wr_d    = res.wr;
      out_duty_d  = res.duty;
      out_busy_d  = res.busy;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_wr_q   <= out_wr_d;
    out_duty_q <= out_duty_d;
    out_busy_q <= out_busy_d;
  end

  assign in_i.ready       = seq_ready;
  assign out_o.valid      = out_valid_q;
  assign out_o.duty_write = out_wr_q;
  assign out_o.duty_level = out_duty_q;
  assign out_o.busy_res   = out_busy_q;

  // After a transaction is taken, the sequencer leaves idle and drops input ready.
  a_ready_drops: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready
  ) else $error("input ready stayed high after an accepted transaction");

  // A result without a duty write always carries duty level zero.
  a_quiet_duty: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.duty_write |-> out_o.duty_level == 8'd0
  ) else $error("duty level not zero on a result without a duty write");

  // The divider is only started when it is free.
  a_div_free: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy
  ) else $error("divider started while still busy");

  // A result handed over by the sequencer is visible in the next cycle.
  a_result_loaded: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    res.valid && emit_ok |=> out_o.valid
  ) else $error("handed-over result missing from the output register");

endmodule

`default_nettype wire
